/* rtl/ple_pkg.sv */
// Shared types and constants for the positional list engine.
// Used by ple_cell and positional_list_engine; depends on nothing.
`default_nettype none

package ple_pkg;

  localparam int unsigned PosW     = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned LenW     = 5;
  localparam int unsigned DefDepth = 16;

  typedef enum logic [1:0] {
    ReqInsert = 2'd0,
    ReqRemove = 2'd1,
    ReqRead   = 2'd2,
    ReqClear  = 2'd3
  } req_e;

  typedef struct packed {
    req_e                     req_type;
    logic [PosW-1:0]          position;
    logic signed [DataW-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DataW-1:0]  read_value;
    logic [LenW-1:0]          length;
  } rsp_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/ple_cell.sv */
// One storage cell of the list: holds one entry and takes from its neighbors.
// Depends on ple_pkg for the control struct and data width.
`default_nettype none

module ple_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CmpW = 5
) (
  input  wire logic                                clk_i,
  input  wire ple_pkg::cell_ctrl_t                 ctrl_i,
  input  wire logic [CmpW-1:0]                     pos_i,
  input  wire logic signed [ple_pkg::DataW-1:0]    value_i,
  input  wire logic signed [ple_pkg::DataW-1:0]    prev_i,
  input  wire logic signed [ple_pkg::DataW-1:0]    next_i,
  output logic signed [ple_pkg::DataW-1:0]         entry_o,
  output logic signed [ple_pkg::DataW-1:0]         rd_o
);

  localparam logic [CmpW-1:0] IdxC = CmpW'(Idx);

  logic signed [ple_pkg::DataW-1:0] entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && (IdxC > pos_i)) begin
      entry_d = prev_i;
    end else if (ctrl_i.ins && (IdxC == pos_i)) begin
      entry_d = value_i;
    end else if (ctrl_i.rem && (IdxC >= pos_i)) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = (IdxC == pos_i) ? entry_q : '0;

endmodule

`default_nettype wire

/* rtl/positional_list_engine.sv */
// Top level of the positional list engine: a row of ple_cell plus length and result logic.
// Depends on ple_pkg and ple_cell.
`default_nettype none

// Each request (insert, remove, read, clear) is taken when in_valid_i and in_ready_o
// are both high, and its result beat is registered on the next edge, so requests flow
// at one per cycle while the result side keeps taking beats. All cells of the row
// shift together on the edge that registers the result beat. Depth sets the number
// of cells; positions and the reported length are 5 bits wide.
module positional_list_engine #(
  parameter int unsigned Depth = ple_pkg::DefDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ple_pkg::req_t  in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ple_pkg::rsp_t       out_rsp_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > ple_pkg::PosW) ? CntW : ple_pkg::PosW;
  localparam logic [CmpW-1:0] DepthC = CmpW'(Depth);

  logic [CntW-1:0]  count_d, count_q;
  logic             out_valid_q;
  ple_pkg::rsp_t    out_rsp_q;
  logic             in_fire;
  logic [CmpW-1:0]  pos_ext, cnt_ext;
  logic             ok_c;
  logic             ins_ok, rem_ok, rd_ok;
  ple_pkg::cell_ctrl_t ctrl;
  logic signed [ple_pkg::DataW-1:0] cell_q [Depth];
  logic signed [ple_pkg::DataW-1:0] cell_rd [Depth];
  logic signed [ple_pkg::DataW-1:0] rd_or;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_ext = CmpW'(in_req_i.position);
  assign cnt_ext = CmpW'(count_q);
  assign ins_ok  = (pos_ext <= cnt_ext) && (cnt_ext != DepthC);
  assign rem_ok  = pos_ext < cnt_ext;
  assign rd_ok   = pos_ext < cnt_ext;

  always_comb begin
    ok_c     = 1'b0;
    count_d  = count_q;
    ctrl.ins = 1'b0;
    ctrl.rem = 1'b0;
    case (in_req_i.req_type)
      ple_pkg::ReqInsert: begin
        ok_c     = ins_ok;
        ctrl.ins = in_fire && ins_ok;
        if (ins_ok) count_d = count_q + CntW'(1);
      end
      ple_pkg::ReqRemove: begin
        ok_c     = rem_ok;
        ctrl.rem = in_fire && rem_ok;
        if (rem_ok) count_d = count_q - CntW'(1);
      end
      ple_pkg::ReqRead: begin
        ok_c = rd_ok;
      end
      ple_pkg::ReqClear: begin
        ok_c    = 1'b1;
        count_d = '0;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    ple_cell #(
      .Idx  (g),
      .CmpW (CmpW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_ext),
      .value_i (in_req_i.value),
      .prev_i  (cell_q[(g == 0) ? 0 : g - 1]),
      .next_i  (cell_q[(g == Depth - 1) ? g : g + 1]),
      .entry_o (cell_q[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < Depth; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_rsp_q.ok         <= ok_c;
      out_rsp_q.read_value <= ((in_req_i.req_type == ple_pkg::ReqRead) && rd_ok) ? rd_or : '0;
      out_rsp_q.length     <= ple_pkg::LenW'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= DepthC)
    else $error("list length above depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_req_i.req_type == ple_pkg::ReqClear)
    |=> out_valid_o && out_rsp_o.ok && (count_q == '0))
    else $error("clear did not empty the list");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_req_i.req_type == ple_pkg::ReqInsert) && ins_ok
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the list");

  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !ok_c |=> $stable(count_q))
    else $error("refused request changed the length");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.ok |-> out_rsp_o.read_value == '0)
    else $error("refused beat carries read data");

endmodule

`default_nettype wire
